/* hw/rtl/ldpd_pkg.sv */
// shared constants, types and the crc-8 step for the lidar packet deframer
// no dependencies; imported by ldpd_ctrl, ldpd_datapath and the top level
`default_nettype none

package ldpd_pkg;

   // packet geometry
   localparam int unsigned POINTS_PER_PACKET = 12;
   localparam int unsigned PKT_LEN = 11 + 3 * POINTS_PER_PACKET;
   localparam int unsigned POS_W = $clog2(PKT_LEN);
   localparam int unsigned ROW_W = $clog2(POINTS_PER_PACKET);

   localparam logic [POS_W-1:0] SPEED_POS = POS_W'(2);
   localparam logic [POS_W-1:0] START_POS = POS_W'(4);
   localparam logic [POS_W-1:0] POINT_POS = POS_W'(6);
   localparam logic [POS_W-1:0] END_POS = POS_W'(6 + 3 * POINTS_PER_PACKET);
   localparam logic [POS_W-1:0] CRC_POS = POS_W'(PKT_LEN - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(POINTS_PER_PACKET - 1);

   // framing bytes and crc polynomial
   localparam logic [7:0] HEADER_BYTE = 8'h54;
   localparam logic [7:0] VERLEN_BYTE = 8'h2C;
   localparam logic [7:0] CRC_POLY = 8'h4D;

   // angle interpolation: floor(i * diff / ANGLE_DIV) by reciprocal multiply
   localparam int unsigned FULL_TURN = 36000;
   localparam int unsigned ANGLE_DIV = POINTS_PER_PACKET - 1;
   localparam int unsigned DIV_W = $clog2(ANGLE_DIV + 1);
   localparam int unsigned X_W = DIV_W + 18;
   localparam int unsigned MUL_SHIFT = X_W;
   localparam int unsigned RECIP_W = X_W + 1;
   localparam int unsigned PROD_W = X_W + RECIP_W;
   localparam int unsigned QD_W = 18;
   localparam int unsigned ANG_W = 19;
   localparam longint unsigned RECIP_VAL =
      ((64'd1 << MUL_SHIFT) + ANGLE_DIV - 1) / ANGLE_DIV;
   localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP_VAL);
   localparam logic [DIV_W-1:0] DIV_K = DIV_W'(ANGLE_DIV);
   localparam logic [X_W-1:0] X_OFFSET = X_W'(ANGLE_DIV * 65536);
   localparam logic [X_W-1:0] X_TURN = X_W'(FULL_TURN);
   localparam logic [X_W-1:0] X_HIGH = X_W'(FULL_TURN + ANGLE_DIV * 65536);

   // configuration registers
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_LOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_HIGH = 1'b1;
   localparam logic [15:0] WRAP_LOW_RESET = 16'd2000;
   localparam logic [15:0] WRAP_HIGH_RESET = 16'd34000;

   // controller states
   typedef enum logic [3:0] {
      ST_HUNT,
      ST_VERLEN,
      ST_COLLECT,
      ST_MUL,
      ST_FIX,
      ST_READ,
      ST_CALC,
      ST_SHOW,
      ST_ERROR
   } ldpd_state_type;

   // controller to datapath
   typedef struct packed {
      logic hdr_take;
      logic verlen_take;
      logic body_take;
      logic pkt_take;
      logic err_load;
      logic mul;
      logic fix;
      logic load_point;
      logic point_next;
   } ldpd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_header;
      logic is_verlen;
      logic crc_ok;
      logic at_crc_byte;
      logic at_last_point;
   } ldpd_status_type;

   // one byte of crc-8, msb first
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ldpd_ctrl.sv */
// controller state machine: byte framing, divide sequencing and point emission
// depends on ldpd_pkg
`default_nettype none

module ldpd_ctrl
   import ldpd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire ldpd_status_type status,
   output ldpd_cmd_type         cmd
);

   ldpd_state_type state_ff;
   ldpd_state_type state_in;
   logic           take;
   logic           give;

   assign take = req_valid && !req_stall;
   assign give = rsp_valid && !rsp_stall;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HUNT: begin
            if (take && status.is_header) state_in = ST_VERLEN;
         end
         ST_VERLEN: begin
            if (take) state_in = status.is_verlen ? ST_COLLECT : ST_HUNT;
         end
         ST_COLLECT: begin
            if (take && status.at_crc_byte) state_in = status.crc_ok ? ST_MUL : ST_ERROR;
         end
         ST_MUL:  state_in = ST_FIX;
         ST_FIX:  state_in = ST_READ;
         ST_READ: state_in = ST_CALC;
         ST_CALC: state_in = ST_SHOW;
         ST_SHOW: begin
            if (give) state_in = status.at_last_point ? ST_HUNT : ST_READ;
         end
         ST_ERROR: begin
            if (give) state_in = ST_HUNT;
         end
         default: state_in = ST_HUNT;
      endcase
   end

   // outputs; stall is low in the byte states, so valid alone marks a taken byte
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_HUNT: begin
            req_stall    = 1'b0;
            cmd.hdr_take = req_valid && status.is_header;
         end
         ST_VERLEN: begin
            req_stall       = 1'b0;
            cmd.verlen_take = req_valid && status.is_verlen;
         end
         ST_COLLECT: begin
            req_stall     = 1'b0;
            cmd.body_take = req_valid && !status.at_crc_byte;
            cmd.pkt_take  = req_valid && status.at_crc_byte && status.crc_ok;
            cmd.err_load  = req_valid && status.at_crc_byte && !status.crc_ok;
         end
         ST_MUL:  cmd.mul = 1'b1;
         ST_FIX:  cmd.fix = 1'b1;
         ST_READ: begin
         end
         ST_CALC: cmd.load_point = 1'b1;
         ST_SHOW: begin
            rsp_valid      = 1'b1;
            cmd.point_next = !rsp_stall;
         end
         ST_ERROR: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

/* hw/rtl/ldpd_datapath.sv */
// datapath: crc, packet field capture, point memory, angle divide and result words
// depends on ldpd_pkg
`default_nettype none

module ldpd_datapath
   import ldpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ldpd_cmd_type         cmd,
   output ldpd_status_type           status,
   input  wire logic [7:0]           rx_byte,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata,
   output logic                      rsp_status,
   output logic [3:0]                rsp_point_index,
   output logic [15:0]               rsp_angle,
   output logic [15:0]               rsp_distance,
   output logic [7:0]                rsp_intensity,
   output logic [15:0]               rsp_motor_speed,
   output logic                      rsp_scan_end,
   output logic                      rsp_last
);

   // configuration
   logic [15:0] wrap_low_ff;
   logic [15:0] wrap_high_ff;

   // framing
   logic [7:0]       crc_ff,  crc_in;
   logic [POS_W-1:0] pos_ff,  pos_in;
   logic [1:0]       col_ff,  col_in;
   logic [ROW_W-1:0] row_ff,  row_in;
   logic [7:0]       dist_lo_ff;
   logic [7:0]       dist_hi_ff;
   logic [15:0]      speed_ff;
   logic [15:0]      start_ff;
   logic [15:0]      end_ff;
   logic             in_points;

   // point memory: {intensity, distance hi, distance lo}
   logic [23:0] pts_mem [POINTS_PER_PACKET];
   logic [23:0] rd_data_ff;

   // scan tracking
   logic [1:0]  pis_ff;
   logic [1:0]  pis_inc;
   logic [15:0] prev_end_ff;
   logic        wrap_ff;
   logic        wrap_in;

   // divide
   logic [X_W-1:0]    t_off;
   logic [X_W-1:0]    x_ff, x_in;
   logic [PROD_W-1:0] prod_ff;
   logic [X_W-1:0]    quo;
   logic [X_W:0]      quo_mul;
   logic [X_W:0]      rem;
   logic [X_W-1:0]    quo_fix;
   logic [X_W:0]      qd_wide;
   logic [DIV_W-1:0]  rd_in;
   logic [QD_W-1:0]   qd_ff;
   logic [DIV_W-1:0]  rd_ff;

   // interpolation accumulator
   logic [QD_W-1:0]  qacc_ff;
   logic [DIV_W-1:0] racc_ff;
   logic [DIV_W:0]   rsum;
   logic             carry;
   logic [ANG_W-1:0] ang_sum;
   logic [ANG_W-1:0] ang_fix;
   logic             last_pt;

   // status to controller
   assign status.is_header     = (rx_byte == HEADER_BYTE);
   assign status.is_verlen     = (rx_byte == VERLEN_BYTE);
   assign status.crc_ok        = (crc_ff == rx_byte);
   assign status.at_crc_byte   = (pos_ff == CRC_POS);
   assign status.at_last_point = (row_ff == LAST_ROW);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_low_ff  <= WRAP_LOW_RESET;
         wrap_high_ff <= WRAP_HIGH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WRAP_LOW:  wrap_low_ff  <= csr_wdata;
            CSR_WRAP_HIGH: wrap_high_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // byte position, crc and point row counters
   assign in_points = (pos_ff >= POINT_POS) && (pos_ff < END_POS);

   always_comb begin
      crc_in = crc_ff;
      pos_in = pos_ff;
      col_in = col_ff;
      row_in = row_ff;
      priority if (cmd.hdr_take) begin
         crc_in = crc8_update(8'h00, rx_byte);
         pos_in = POS_W'(1);
      end else if (cmd.verlen_take) begin
         crc_in = crc8_update(crc_ff, rx_byte);
         pos_in = POS_W'(2);
         col_in = 2'd0;
         row_in = '0;
      end else if (cmd.body_take) begin
         crc_in = crc8_update(crc_ff, rx_byte);
         pos_in = pos_ff + POS_W'(1);
         if (in_points) begin
            if (col_ff == 2'd2) begin
               col_in = 2'd0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + 2'd1;
            end
         end
      end else if (cmd.fix) begin
         row_in = '0;
      end else if (cmd.point_next) begin
         row_in = row_ff + ROW_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 8'h00;
         pos_ff <= POS_W'(1);
         col_ff <= 2'd0;
         row_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // fixed packet fields
   always_ff @(posedge clock) begin
      if (cmd.body_take) begin
         if (pos_ff == SPEED_POS)              speed_ff[7:0]  <= rx_byte;
         if (pos_ff == SPEED_POS + POS_W'(1))  speed_ff[15:8] <= rx_byte;
         if (pos_ff == START_POS)              start_ff[7:0]  <= rx_byte;
         if (pos_ff == START_POS + POS_W'(1))  start_ff[15:8] <= rx_byte;
         if (pos_ff == END_POS)                end_ff[7:0]    <= rx_byte;
         if (pos_ff == END_POS + POS_W'(1))    end_ff[15:8]   <= rx_byte;
         if (in_points && col_ff == 2'd0)      dist_lo_ff     <= rx_byte;
         if (in_points && col_ff == 2'd1)      dist_hi_ff     <= rx_byte;
      end
   end

   // point memory, one row per point
   always_ff @(posedge clock) begin
      if (cmd.body_take && in_points && col_ff == 2'd2) begin
         pts_mem[row_ff] <= {rx_byte, dist_hi_ff, dist_lo_ff};
      end
      rd_data_ff <= pts_mem[row_ff];
   end

   // revolution wrap on a good packet
   assign pis_inc = (pis_ff < 2'd2) ? pis_ff + 2'd1 : pis_ff;
   assign wrap_in = (pis_inc == 2'd2) && (end_ff < wrap_low_ff) && (prev_end_ff > wrap_high_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pis_ff      <= 2'd0;
         prev_end_ff <= 16'd0;
         wrap_ff     <= 1'b0;
      end else if (cmd.pkt_take) begin
         wrap_ff <= wrap_in;
         if (wrap_in) begin
            pis_ff <= 2'd0;
         end else begin
            pis_ff      <= pis_inc;
            prev_end_ff <= end_ff;
         end
      end
   end

   // span to the end angle, offset so the dividend stays positive
   assign t_off = X_W'(end_ff) + X_HIGH - X_W'(start_ff);
   assign x_in  = (t_off > X_HIGH) ? t_off - X_TURN : t_off;

   // reciprocal multiply, then one correction step
   assign quo     = prod_ff[MUL_SHIFT +: X_W];
   assign quo_mul = (X_W + 1)'(quo * DIV_K);
   assign rem     = {1'b0, x_ff} - quo_mul;

   always_comb begin
      if (rem[X_W]) begin
         quo_fix = quo - X_W'(1);
         rd_in   = DIV_W'(rem + (X_W + 1)'(DIV_K));
      end else begin
         quo_fix = quo;
         rd_in   = rem[DIV_W-1:0];
      end
   end

   assign qd_wide = {1'b0, quo_fix} - {1'b0, X_W'(65536)};

   always_ff @(posedge clock) begin
      if (cmd.pkt_take) x_ff <= x_in;
      if (cmd.mul) prod_ff <= PROD_W'(x_ff) * PROD_W'(RECIP_K);
      if (cmd.fix) begin
         qd_ff <= qd_wide[QD_W-1:0];
         rd_ff <= rd_in;
      end
   end

   // running floor(i * diff / div) as quotient and remainder
   assign rsum  = {1'b0, racc_ff} + {1'b0, rd_ff};
   assign carry = (rsum >= {1'b0, DIV_K});

   always_ff @(posedge clock) begin
      if (cmd.fix) begin
         qacc_ff <= '0;
         racc_ff <= '0;
      end else if (cmd.point_next) begin
         qacc_ff <= qacc_ff + qd_ff + QD_W'(carry);
         racc_ff <= carry ? DIV_W'(rsum - {1'b0, DIV_K}) : rsum[DIV_W-1:0];
      end
   end

   // point angle with one turn folded back
   assign ang_sum = ANG_W'(start_ff) + {qacc_ff[QD_W-1], qacc_ff};
   assign ang_fix = ($signed(ang_sum) >= $signed(ANG_W'(FULL_TURN)))
                    ? ang_sum - ANG_W'(FULL_TURN) : ang_sum;
   assign last_pt = (row_ff == LAST_ROW);

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.err_load) begin
         rsp_status      <= 1'b1;
         rsp_point_index <= 4'd0;
         rsp_angle       <= 16'd0;
         rsp_distance    <= 16'd0;
         rsp_intensity   <= 8'd0;
         rsp_motor_speed <= 16'd0;
         rsp_scan_end    <= 1'b0;
         rsp_last        <= 1'b1;
      end else if (cmd.load_point) begin
         rsp_status      <= 1'b0;
         rsp_point_index <= 4'(row_ff);
         rsp_angle       <= ang_fix[15:0];
         rsp_distance    <= rd_data_ff[15:0];
         rsp_intensity   <= rd_data_ff[23:16];
         rsp_motor_speed <= speed_ff;
         rsp_scan_end    <= last_pt && wrap_ff;
         rsp_last        <= last_pt;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lidar_packet_deframer_crc_points.sv */
// lidar packet deframer: one byte word per cycle while framing a 47-byte packet.
// after the crc byte: angle divide setup (multiply, then correction), then per point
// a memory read, angle compute and result register step plus any rsp_stall; 12 points.
// a crc mismatch gives one error word the cycle after the crc byte.
// no byte is taken while a packet's words are being sent.
// synchronous active-high reset: hunting for header, config at 2000/34000.
`default_nettype none

module lidar_packet_deframer_crc_points
   import ldpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_rx_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_status,
   output logic [3:0]                rsp_point_index,
   output logic [15:0]               rsp_angle,
   output logic [15:0]               rsp_distance,
   output logic [7:0]                rsp_intensity,
   output logic [15:0]               rsp_motor_speed,
   output logic                      rsp_scan_end,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata
);

   ldpd_cmd_type    cmd;
   ldpd_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   // controller
   ldpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   ldpd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rx_byte         (req_rx_byte),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_status      (rsp_status),
      .rsp_point_index (rsp_point_index),
      .rsp_angle       (rsp_angle),
      .rsp_distance    (rsp_distance),
      .rsp_intensity   (rsp_intensity),
      .rsp_motor_speed (rsp_motor_speed),
      .rsp_scan_end    (rsp_scan_end),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire
